[design/tssq_pkg.sv]
// ----------------------------------------------------------------------------
// tssq_pkg
// Shared types and constants of the timestamped sample store.
// ----------------------------------------------------------------------------
package tssq_pkg;

  // Number of cells in the chain (1 to 64).
  localparam int CAPACITY  = 64;
  // Width of a count of entries, 0 to CAPACITY inclusive.
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  // Width of the sequencer's step counter, wide enough for a compaction sweep.
  localparam int STEP_W    = $clog2(2 * CAPACITY);

  localparam int STAMP_W   = 32;
  localparam int VALUE_W   = 32;
  localparam int REMOVED_W = 7;
  localparam int OPCODE_W  = 2;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 80;

  // Opcodes of an input transaction.
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PURGE  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NONE   = 2'd3;

  // Cell operating modes.
  localparam logic [1:0] MODE_HOLD    = 2'd0;
  localparam logic [1:0] MODE_SHIFT   = 2'd1; // take the lower neighbor (insert)
  localparam logic [1:0] MODE_ROTATE  = 2'd2; // take the upper neighbor
  localparam logic [1:0] MODE_COMPACT = 2'd3; // swap a hole with the upper neighbor

  typedef struct packed {
    logic                      valid;
    logic signed [STAMP_W-1:0] stamp;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0] mode;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [STAMP_W-1:0] stamp;
    logic signed [VALUE_W-1:0] value;
    logic                      match;
    logic                      last;
    logic                      status;
    logic [REMOVED_W-1:0]      removed;
  } result_t;

endpackage

[design/tssq_cell.sv]
// ----------------------------------------------------------------------------
// tssq_cell
// One storage cell of the sample chain: a valid bit, a timestamp and a value.
// ----------------------------------------------------------------------------
module tssq_cell
  import tssq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    lower,   // neighbor toward slot 0 (insert data for slot 0)
  input  entry_t    upper,   // neighbor toward the tail
  output entry_t    cur
);

  logic                      valid_r;
  logic signed [STAMP_W-1:0] stamp_r;
  logic signed [VALUE_W-1:0] value_r;
  entry_t                    ent_nxt;

  assign cur = '{valid: valid_r, stamp: stamp_r, value: value_r};

  always_comb begin
    unique case (cmd.mode)
      MODE_HOLD:   ent_nxt = cur;
      MODE_SHIFT:  ent_nxt = lower;
      MODE_ROTATE: ent_nxt = upper;
      MODE_COMPACT: begin
        // A hole pulls its upper neighbor; an entry pulled by a hole below leaves one.
        if (!valid_r) begin
          ent_nxt = upper;
        end else if (!lower.valid) begin
          ent_nxt       = cur;
          ent_nxt.valid = 1'b0;
        end else begin
          ent_nxt = cur;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= ent_nxt.stamp;
    value_r <= ent_nxt.value;
  end

endmodule

[design/tssq_ctrl.sv]
// ----------------------------------------------------------------------------
// tssq_ctrl
// Sequencer: takes input transactions, drives the cell chain, checks the head
// cell and produces result transactions.
// ----------------------------------------------------------------------------
module tssq_ctrl
  import tssq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [OPCODE_W-1:0]  in_tuser,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  entry_t               head,
  input  logic                 full,
  input  logic                 out_free,
  output cell_cmd_t            cell_cmd,
  output entry_t               ins_entry,
  output entry_t               tail_entry,
  output logic                 res_write,
  output result_t              res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INS  = 3'd1;
  localparam logic [2:0] ST_QRY  = 3'd2;
  localparam logic [2:0] ST_PRG  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [CNT_W-1:0]          removed_r, removed_nxt;
  logic                      status_r, status_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic                      pend_load;
  logic signed [STAMP_W-1:0] pend_t_r;
  logic signed [VALUE_W-1:0] pend_val_r;

  logic                      accept;
  logic [OPCODE_W-1:0]       in_op;
  logic signed [STAMP_W-1:0] ins_t_r, lo_r, hi_r, cut_r;
  logic signed [VALUE_W-1:0] ins_v_r;

  logic hit, drop, rot_end, cmp_end;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_op     = in_tuser;

  assign hit  = head.valid && (head.stamp >= lo_r) && (head.stamp <= hi_r);
  assign drop = head.valid && (head.stamp < cut_r);

  assign rot_end = (step_r == STEP_W'(CAPACITY - 1));
  assign cmp_end = (step_r == STEP_W'(2 * CAPACITY - 1));

  assign ins_entry = '{valid: 1'b1, stamp: ins_t_r, value: ins_v_r};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    pend_v_nxt    = pend_v_r;
    pend_load     = 1'b0;
    cell_cmd.mode = MODE_HOLD;
    tail_entry    = head;
    res_write     = 1'b0;
    // Carry a sample only while one is pending; otherwise the fields read zero.
    res.stamp     = pend_v_r ? pend_t_r : '0;
    res.value     = pend_v_r ? pend_val_r : '0;
    res.match     = pend_v_r;
    res.last      = 1'b1;
    res.status    = status_r;
    res.removed   = REMOVED_W'(removed_r);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          step_nxt    = '0;
          removed_nxt = '0;
          status_nxt  = 1'b0;
          pend_v_nxt  = 1'b0;
          unique case (in_op)
            OP_INSERT: state_nxt = ST_INS;
            OP_QUERY:  state_nxt = ST_QRY;
            OP_PURGE:  state_nxt = ST_PRG;
            OP_NONE:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INS: begin
        if (full) begin
          status_nxt = 1'b1;
        end else begin
          cell_cmd.mode = MODE_SHIFT;
        end
        state_nxt = ST_DONE;
      end
      ST_QRY: begin
        // Hold the chain while the head is a new match and an older match waits for the output register.
        if (!(hit && pend_v_r && !out_free)) begin
          cell_cmd.mode = MODE_ROTATE;
          step_nxt      = step_r + 1'b1;
          if (hit) begin
            pend_v_nxt = 1'b1;
            pend_load  = 1'b1;
            res_write  = pend_v_r;
            res.last   = 1'b0;
          end
          if (rot_end) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PRG: begin
        cell_cmd.mode    = MODE_ROTATE;
        tail_entry.valid = head.valid && !drop;
        step_nxt         = step_r + 1'b1;
        if (drop) begin
          removed_nxt = removed_r + 1'b1;
        end
        if (rot_end) begin
          step_nxt  = '0;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cell_cmd.mode    = MODE_COMPACT;
        tail_entry.valid = 1'b0;
        step_nxt         = step_r + 1'b1;
        if (cmp_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_write = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      removed_r <= '0;
      status_r  <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
      pend_v_r  <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ins_t_r <= in_tdata[31:0];
      ins_v_r <= in_tdata[63:32];
      lo_r    <= in_tdata[95:64];
      hi_r    <= in_tdata[127:96];
      cut_r   <= in_tdata[159:128];
    end
    if (pend_load) begin
      pend_t_r   <= head.stamp;
      pend_val_r <= head.value;
    end
  end

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_write |-> out_free)
    else $error("result written while output register is occupied");

  a_ins_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |=> (state_r == ST_DONE))
    else $error("insert did not finish in one cycle");

  a_prg_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRG) && rot_end |=> (state_r == ST_CMP) && (step_r == '0))
    else $error("purge sweep did not hand over to compaction");

endmodule

[design/timestamped_sample_store_window_query_unit.sv]
// ----------------------------------------------------------------------------
// timestamped_sample_store_window_query_unit
// Newest-first store of timestamped samples with insert, window query, purge.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on in_tvalid/in_tready/in_tdata, with in_tuser
//   carrying the opcode: insert a sample, query a timestamp window, or purge
//   samples older than a cutoff. Results leave on out_tvalid/out_tready/
//   out_tdata with out_tuser flagging a matching sample and out_tlast closing
//   each run. Samples sit in a chain of CAPACITY cells, slot 0 newest. An
//   insert shifts the chain up by one cell unless the store is full. Query
//   and purge rotate the whole chain through the head cell, so every entry
//   passes the one window/cutoff compare and the order is restored at the end.
//   A purge then runs a compaction in which holes bubble to the tail.
//   Reset clears all cell valid bits (the store is empty) and the sequencer;
//   stored data is not reset. in_tready is high only between items. A stalled
//   receiver holds the result in the output register; a query then freezes
//   its rotation until the register frees up, so no result is lost.
// ----------------------------------------------------------------------------
module timestamped_sample_store_window_query_unit
  import tssq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // opcode
  input  logic [OPCODE_W-1:0]   in_tuser,
  // sample_time[31:0], sample_value[63:32], window_start[95:64],
  // window_end[127:96], cutoff_time[159:128]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_time[31:0], out_value[63:32], status[64], removed_count[71:65], pad to 80
  output logic [OUT_DATA_W-1:0] out_tdata,
  // match_found
  output logic                  out_tuser,
  // last_of_run
  output logic                  out_tlast
);

  cell_cmd_t             cell_cmd;
  entry_t                ins_entry, tail_entry;
  entry_t                ent  [CAPACITY];
  entry_t                lower[CAPACITY];
  entry_t                upper[CAPACITY];
  logic [CAPACITY-1:0]   valid_vec;
  logic                  out_free, res_write;
  result_t               res;
  logic                  out_valid_r;
  result_t               out_res_r;

  // Chain of cells: slot 0 is the head and newest entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lower[i] = ins_entry;
    end else begin : g_mid_lo
      assign lower[i] = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign upper[i] = tail_entry;
    end else begin : g_mid_hi
      assign upper[i] = ent[i+1];
    end
    assign valid_vec[i] = ent[i].valid;

    tssq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cell_cmd),
      .lower (lower[i]),
      .upper (upper[i]),
      .cur   (ent[i])
    );
  end

  tssq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .head       (ent[0]),
    .full       (ent[CAPACITY-1].valid),
    .out_free   (out_free),
    .cell_cmd   (cell_cmd),
    .ins_entry  (ins_entry),
    .tail_entry (tail_entry),
    .res_write  (res_write),
    .res        (res)
  );

  // Output register: load when empty or being drained in the same cycle.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_write;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {8'd0, out_res_r.removed, out_res_r.status,
                       out_res_r.value, out_res_r.stamp};
  assign out_tuser  = out_res_r.match;
  assign out_tlast  = out_res_r.last;

  // Between items the valid entries form an unbroken run from slot 0.
  a_compacted: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("store not compacted between items");

  // Returning to idle always follows the closing result of the item.
  a_closed_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> $past(res_write) && out_valid_r && out_tlast)
    else $error("item finished without a closing result");

  // A closing result from a full store must not move the chain.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_write && res.status |-> $stable(valid_vec))
    else $error("refused insert changed the store");

endmodule

[dv/timestamped_sample_store_window_query_unit_test.sv]
// ----------------------------------------------------------------------------
// timestamped_sample_store_window_query_unit_test
// Self-checking bench for the timestamped sample store. A generator queues
// inserts, window queries, purges and unused opcodes. It starts with a short
// directed list and then issues random segments that fill, query and trim the
// store. A clocked driver offers them in bursts. A clocked monitor stalls the
// result channel on its own pattern. It checks every result transaction field
// by field against a behavioral store that is updated whenever an input
// transaction is accepted.
// ----------------------------------------------------------------------------
module timestamped_sample_store_window_query_unit_test
  import tssq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RESET_CYCLES = 10;
  localparam int     RANDOM_OPS   = 500;
  // Idle time at the end, chosen to outlast a purge.
  localparam int     DRAIN_CYCLES = 4 * CAPACITY;
  localparam int     HOLD_CYCLES  = 400;
  localparam longint CYCLE_LIMIT  = 2_000_000;
  localparam int     REPORT_MAX   = 10;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic signed [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
  localparam logic signed [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // One input transaction. The opcode travels on in_tuser; the fields above it
  // pack into in_tdata from the lowest bit up.
  typedef struct packed {
    logic signed [STAMP_W-1:0] cutoff_time;
    logic signed [STAMP_W-1:0] window_end;
    logic signed [STAMP_W-1:0] window_start;
    logic signed [VALUE_W-1:0] sample_value;
    logic signed [STAMP_W-1:0] sample_time;
    logic [OPCODE_W-1:0]       opcode;
  } store_op_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OPCODE_W-1:0]   in_tuser   = '0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  timestamped_sample_store_window_query_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral store: newest sample in slot 0, compacted, updated per accepted
  // input transaction. Every result the block owes is queued in due_results.
  // --------------------------------------------------------------------------
  logic signed [STAMP_W-1:0] stored_stamp [CAPACITY];
  logic signed [VALUE_W-1:0] stored_value [CAPACITY];
  int unsigned               stored_count = 0;
  result_t                   due_results[$];

  int unsigned n_inserts = 0, n_refused = 0, n_queries = 0, n_matches = 0;
  int unsigned n_purges = 0, n_removed = 0, n_unused = 0;

  // Append a result to the tail of the due list.
  function automatic void owe_result(result_t res);
    due_results.insert(due_results.size(), res);
  endfunction

  function automatic void apply_store_op(store_op_t op);
    result_t     done_res;
    result_t     hit_res;
    result_t     prev_hit;
    bit          have_prev;
    int unsigned i;
    int unsigned keep;

    done_res      = '0;
    done_res.last = 1'b1;
    have_prev     = 1'b0;
    prev_hit      = '0;
    keep          = 0;
    case (op.opcode)
      OP_INSERT: begin
        n_inserts++;
        if (stored_count >= CAPACITY) begin
          // Full: refuse and leave the store alone.
          done_res.status = STATUS_FULL;
          n_refused++;
        end else begin
          for (i = stored_count; i > 0; i--) begin
            stored_stamp[i] = stored_stamp[i-1];
            stored_value[i] = stored_value[i-1];
          end
          stored_stamp[0] = op.sample_time;
          stored_value[0] = op.sample_value;
          stored_count++;
          done_res.status = STATUS_OK;
        end
        owe_result(done_res);
      end
      OP_QUERY: begin
        n_queries++;
        // Hold each hit back by one so the final one can carry last.
        for (i = 0; i < stored_count; i++) begin
          if (stored_stamp[i] >= op.window_start && stored_stamp[i] <= op.window_end) begin
            hit_res       = '0;
            hit_res.stamp = stored_stamp[i];
            hit_res.value = stored_value[i];
            hit_res.match = 1'b1;
            if (have_prev) owe_result(prev_hit);
            prev_hit  = hit_res;
            have_prev = 1'b1;
            n_matches++;
          end
        end
        if (have_prev) begin
          prev_hit.last = 1'b1;
          owe_result(prev_hit);
        end else begin
          owe_result(done_res);
        end
      end
      OP_PURGE: begin
        n_purges++;
        for (i = 0; i < stored_count; i++) begin
          if (stored_stamp[i] >= op.cutoff_time) begin
            stored_stamp[keep] = stored_stamp[i];
            stored_value[keep] = stored_value[i];
            keep++;
          end
        end
        done_res.removed = REMOVED_W'(stored_count - keep);
        n_removed += stored_count - keep;
        stored_count = keep;
        owe_result(done_res);
      end
      default: begin
        // Unused opcode: a bare closing result.
        n_unused++;
        owe_result(done_res);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation. planned_stamps tracks what the store will hold once
  // everything queued so far is applied, so windows and cutoffs can be aimed
  // at real entries and fills can stop exactly at capacity.
  // --------------------------------------------------------------------------
  store_op_t                 op_queue[$];
  logic signed [STAMP_W-1:0] planned_stamps[$];
  int unsigned               planned_ops = 0;

  function automatic void queue_op(store_op_t op);
    logic signed [STAMP_W-1:0] kept[$];
    op_queue.insert(op_queue.size(), op);
    if (op.opcode != OP_NONE) planned_ops++;
    case (op.opcode)
      OP_INSERT: begin
        if (planned_stamps.size() < CAPACITY) planned_stamps.push_front(op.sample_time);
      end
      OP_PURGE: begin
        foreach (planned_stamps[i]) begin
          if (planned_stamps[i] >= op.cutoff_time) kept.insert(kept.size(), planned_stamps[i]);
        end
        planned_stamps = kept;
      end
      default: ;
    endcase
  endfunction

  // Randomize every field so that unused fields still toggle every bit.
  function automatic store_op_t random_op(logic [OPCODE_W-1:0] code);
    store_op_t op;
    op.sample_time  = $urandom;
    op.sample_value = $urandom;
    op.window_start = $urandom;
    op.window_end   = $urandom;
    op.cutoff_time  = $urandom;
    op.opcode       = code;
    return op;
  endfunction

  // Mostly a narrow band around zero so that windows and cutoffs hit often.
  function automatic logic signed [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(0, 9))
      0:       return STAMP_MIN + $urandom_range(0, 3);
      1:       return STAMP_MAX - $urandom_range(0, 3);
      2, 3:    return $urandom;
      default: return int'($urandom_range(0, 400)) - 200;
    endcase
  endfunction

  // Land on, or right next to, a stored stamp most of the time.
  function automatic logic signed [STAMP_W-1:0] pick_bound();
    if (planned_stamps.size() != 0 && $urandom_range(0, 2) != 0)
      return planned_stamps[$urandom_range(0, planned_stamps.size() - 1)]
             + (int'($urandom_range(0, 2)) - 1);
    return pick_stamp();
  endfunction

  function automatic void add_insert(logic signed [STAMP_W-1:0] stamp,
                                     logic signed [VALUE_W-1:0] value);
    store_op_t op;
    op              = random_op(OP_INSERT);
    op.sample_time  = stamp;
    op.sample_value = value;
    queue_op(op);
  endfunction

  function automatic void add_query(logic signed [STAMP_W-1:0] lo,
                                    logic signed [STAMP_W-1:0] hi);
    store_op_t op;
    op              = random_op(OP_QUERY);
    op.window_start = lo;
    op.window_end   = hi;
    queue_op(op);
  endfunction

  function automatic void add_purge(logic signed [STAMP_W-1:0] cutoff);
    store_op_t op;
    op             = random_op(OP_PURGE);
    op.cutoff_time = cutoff;
    queue_op(op);
  endfunction

  // Fill up to capacity, then push a few more that must be refused.
  function automatic void fill_store();
    while (planned_stamps.size() < CAPACITY) add_insert(pick_stamp(), $urandom);
    repeat ($urandom_range(1, 3)) add_insert(pick_stamp(), $urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Predict at the
  // edge where the transaction is accepted, then advance to the next one.
  // --------------------------------------------------------------------------
  store_op_t   offered_op;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) apply_store_op(offered_op);
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          offered_op = op_queue.pop_front();
          in_tuser   <= offered_op.opcode;
          in_tdata   <= offered_op[OPCODE_W +: IN_DATA_W];
          in_tvalid  <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, once, in the middle of a multi-result query.
  // The sender keeps offering, so the block must back up and stall its input.
  // --------------------------------------------------------------------------
  int unsigned hold_left      = 0;
  int unsigned mid_query_seen = 0;
  bit          hold_done      = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left      <= 0;
      mid_query_seen <= 0;
      hold_done      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (out_tvalid && out_tuser && !out_tlast) begin
      mid_query_seen <= mid_query_seen + 1;
      if (!hold_done && mid_query_seen >= 40) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest one due, then pick
  // the next out_tready from a stall style that changes every so often.
  // --------------------------------------------------------------------------
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned rx_style     = 0;
  int unsigned rx_left      = 0;
  bit          rx_take;
  result_t     seen_res;
  result_t     due_res;

  function automatic void flag_result(string why, result_t want_res, result_t got_res);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] %s: expected time=%0d value=%0d match=%b last=%b status=%b removed=%0d;",
               $time, why, want_res.stamp, want_res.value, want_res.match, want_res.last,
               want_res.status, want_res.removed,
               "  got time=%0d value=%0d match=%b last=%b status=%b removed=%0d",
               got_res.stamp, got_res.value, got_res.match, got_res.last,
               got_res.status, got_res.removed);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_left    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        seen_res.stamp   = out_tdata[STAMP_W-1:0];
        seen_res.value   = out_tdata[STAMP_W +: VALUE_W];
        seen_res.status  = out_tdata[STAMP_W+VALUE_W];
        seen_res.removed = out_tdata[STAMP_W+VALUE_W+1 +: REMOVED_W];
        seen_res.match   = out_tuser;
        seen_res.last    = out_tlast;
        if (due_results.size() == 0) begin
          flag_result("result with nothing due", '0, seen_res);
        end else begin
          due_res = due_results.pop_front();
          if (seen_res.stamp !== due_res.stamp || seen_res.value !== due_res.value ||
              seen_res.match !== due_res.match || seen_res.last !== due_res.last ||
              seen_res.status !== due_res.status || seen_res.removed !== due_res.removed)
            flag_result("result mismatch", due_res, seen_res);
        end
      end

      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_left  = $urandom_range(16, 160);
      end else begin
        rx_left--;
      end
      case (rx_style)
        0:       rx_take = 1'b1;                          // no stalls at all
        1:       rx_take = ($urandom_range(0, 3) != 0);   // occasional stall
        2:       rx_take = ($urandom_range(0, 3) == 0);   // mostly stalled
        default: rx_take = 1'($urandom_range(0, 1));
      endcase
      out_tready <= (hold_left == 0) && rx_take;
    end
  end

  // Hard stop in case the block hangs or drops results.
  longint unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results still due",
               cycle_count, due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned               directed_ops;
    logic signed [STAMP_W-1:0] lo;
    logic signed [STAMP_W-1:0] hi;

    // Directed: empty store, extreme stamps and values, window edge cases.
    add_query(STAMP_MIN, STAMP_MAX);     // empty store gives a bare no-match
    add_purge(STAMP_MAX);                // empty store removes nothing
    add_insert(STAMP_MAX, VALUE_MIN);
    add_insert(STAMP_MIN, VALUE_MAX);
    add_insert(0, 0);
    add_insert(-1, -1);
    add_insert(1, 32'sh0001_0000);
    add_query(STAMP_MIN, STAMP_MAX);     // everything, newest first
    add_query(1, -1);                    // reversed window matches nothing
    add_query(0, 0);
    add_query(STAMP_MAX, STAMP_MAX);
    add_query(STAMP_MIN, STAMP_MIN);
    add_query(-1, 1);
    queue_op(random_op(OP_NONE));
    add_purge(STAMP_MIN);                // nothing lies below the minimum
    add_purge(0);                        // drops the minimum and -1
    add_query(STAMP_MIN, STAMP_MAX);
    add_purge(STAMP_MAX);                // keeps only the maximum
    add_query(STAMP_MAX, STAMP_MAX);
    add_insert(-5, 7);
    queue_op(random_op(OP_NONE));
    add_query(-5, STAMP_MAX);
    directed_ops = planned_ops;

    // Random: start from a full store, then mix segments.
    fill_store();
    while (planned_ops < directed_ops + RANDOM_OPS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          repeat ($urandom_range(1, 12)) add_insert(pick_stamp(), $urandom);
        end
        7, 8, 9, 10, 11: begin
          lo = pick_bound();
          hi = pick_bound();
          // Mostly ordered windows; keep some reversed ones.
          if (lo > hi && $urandom_range(0, 5) != 0) add_query(hi, lo);
          else add_query(lo, hi);
        end
        12:          add_query(STAMP_MIN, STAMP_MAX);
        13, 14, 15:  add_purge(pick_bound());
        16:          fill_store();
        17:          queue_op(random_op(OP_NONE));
        default: begin
          add_insert(pick_stamp(), $urandom);
          add_query(pick_bound(), STAMP_MAX);
        end
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to go in and every result to come back, then
    // idle a while to catch anything extra.
    while (op_queue.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d inserts (%0d refused on a full store), %0d window queries (%0d hits),",
             n_inserts, n_refused, n_queries, n_matches);
    $display("%0d purges (%0d samples dropped), %0d unused opcodes; %0d results checked.",
             n_purges, n_removed, n_unused, results_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d result transactions were wrong", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
